/* rtl/ss5_pkg.sv */
// Shared types, constants and helper functions of the SS5 tone pair generator.
`default_nettype none

package ss5_pkg;

    // Run length limit and phase table geometry
    localparam int DEFAULT_MAX_RUN = 64;
    localparam int TBL_LOG2        = 13;
    localparam int TABLE_LENGTH    = 2 ** TBL_LOG2;
    localparam int FRAC_W          = TBL_LOG2 - 2;

    // Quarter turn in Q30 radians
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Number of Taylor terms after the linear one
    localparam int TERM_COUNT = 6;

    // Companding law codes
    localparam logic LAW_A  = 1'b0;
    localparam logic LAW_MU = 1'b1;

    // Phase increments per sample, round(f * TABLE_LENGTH / 8000)
    localparam logic [TBL_LOG2-1:0] STEP_700  = TBL_LOG2'((700  * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_900  = TBL_LOG2'((900  * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_1100 = TBL_LOG2'((1100 * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_1300 = TBL_LOG2'((1300 * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_1500 = TBL_LOG2'((1500 * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_1700 = TBL_LOG2'((1700 * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_2400 = TBL_LOG2'((2400 * TABLE_LENGTH + 4000) / 8000);
    localparam logic [TBL_LOG2-1:0] STEP_2600 = TBL_LOG2'((2600 * TABLE_LENGTH + 4000) / 8000);

    // Tone gains scaled by 1e8
    localparam logic [24:0] GAIN_M7DB = 25'd19952623;
    localparam logic [24:0] GAIN_M9DB = 25'd12589254;

    // Gain scaling: divide by 2^15 * 1e8 = 2^23 * 390625
    localparam int          GAIN_SHIFT = 23;
    localparam logic [31:0] GAIN_DIV   = 32'd390625;
    localparam logic [31:0] GAIN_RECIP = 32'((64'd1 << 50) / 64'd390625);
    localparam int          GAIN_QSH   = 50;

    // Taylor term divisors (2k)(2k+1) and their reciprocals in Q32
    localparam logic [7:0]  TERM_DIV_1   = 8'd6;
    localparam logic [7:0]  TERM_DIV_2   = 8'd20;
    localparam logic [7:0]  TERM_DIV_3   = 8'd42;
    localparam logic [7:0]  TERM_DIV_4   = 8'd72;
    localparam logic [7:0]  TERM_DIV_5   = 8'd110;
    localparam logic [7:0]  TERM_DIV_6   = 8'd156;
    localparam logic [31:0] TERM_RECIP_1 = 32'((64'd1 << 32) / 64'd6);
    localparam logic [31:0] TERM_RECIP_2 = 32'((64'd1 << 32) / 64'd20);
    localparam logic [31:0] TERM_RECIP_3 = 32'((64'd1 << 32) / 64'd42);
    localparam logic [31:0] TERM_RECIP_4 = 32'((64'd1 << 32) / 64'd72);
    localparam logic [31:0] TERM_RECIP_5 = 32'((64'd1 << 32) / 64'd110);
    localparam logic [31:0] TERM_RECIP_6 = 32'((64'd1 << 32) / 64'd156);

    // Signalling digit characters
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_1     = "1";
    localparam logic [7:0] CH_2     = "2";
    localparam logic [7:0] CH_3     = "3";
    localparam logic [7:0] CH_4     = "4";
    localparam logic [7:0] CH_5     = "5";
    localparam logic [7:0] CH_6     = "6";
    localparam logic [7:0] CH_7     = "7";
    localparam logic [7:0] CH_8     = "8";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_KP1   = "a";
    localparam logic [7:0] CH_KP2   = "b";
    localparam logic [7:0] CH_ST    = "c";
    localparam logic [7:0] CH_LINE_A = "A";
    localparam logic [7:0] CH_LINE_B = "B";
    localparam logic [7:0] CH_LINE_C = "C";

    typedef enum logic [3:0] {
        TONE_NONE,
        TONE_700,
        TONE_900,
        TONE_1100,
        TONE_1300,
        TONE_1500,
        TONE_1700,
        TONE_2400,
        TONE_2600
    } t_tone;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PHASE,
        OP_ANGLE,
        OP_SQR,
        OP_TMUL,
        OP_TEST,
        OP_TREM,
        OP_TFIX,
        OP_GMUL,
        OP_GEST,
        OP_GREM,
        OP_GFIX,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_PHASE,
        S_ANGLE,
        S_SQR,
        S_TMUL,
        S_TEST,
        S_TREM,
        S_TFIX,
        S_GMUL,
        S_GEST,
        S_GREM,
        S_GFIX,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [2:0] term_idx;
        logic       tone_sel;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic found;
        logic has_tone2;
    } t_dp_status;

    typedef struct packed {
        logic  found;
        t_tone tone1;
        t_tone tone2;
    } t_digit_info;

    // Digit to tone pair
    function automatic t_digit_info f_digit_decode(input logic [7:0] code);
        t_digit_info info;
        info.found = 1'b1;
        info.tone1 = TONE_NONE;
        info.tone2 = TONE_NONE;
        unique case (code)
            CH_1: begin info.tone1 = TONE_700;  info.tone2 = TONE_900;  end
            CH_2: begin info.tone1 = TONE_700;  info.tone2 = TONE_1100; end
            CH_3: begin info.tone1 = TONE_900;  info.tone2 = TONE_1100; end
            CH_4: begin info.tone1 = TONE_700;  info.tone2 = TONE_1300; end
            CH_5: begin info.tone1 = TONE_900;  info.tone2 = TONE_1300; end
            CH_6: begin info.tone1 = TONE_1100; info.tone2 = TONE_1300; end
            CH_7: begin info.tone1 = TONE_700;  info.tone2 = TONE_1500; end
            CH_8: begin info.tone1 = TONE_900;  info.tone2 = TONE_1500; end
            CH_9: begin info.tone1 = TONE_1100; info.tone2 = TONE_1500; end
            CH_0: begin info.tone1 = TONE_1300; info.tone2 = TONE_1500; end
            CH_STAR: begin info.tone1 = TONE_700;  info.tone2 = TONE_1700; end
            CH_HASH: begin info.tone1 = TONE_900;  info.tone2 = TONE_1700; end
            CH_KP1:  begin info.tone1 = TONE_1100; info.tone2 = TONE_1700; end
            CH_KP2:  begin info.tone1 = TONE_1300; info.tone2 = TONE_1700; end
            CH_ST:   begin info.tone1 = TONE_1500; info.tone2 = TONE_1700; end
            CH_LINE_A: info.tone1 = TONE_2400;
            CH_LINE_B: info.tone1 = TONE_2600;
            CH_LINE_C: begin info.tone1 = TONE_2400; info.tone2 = TONE_2600; end
            default: info.found = 1'b0;
        endcase
        return info;
    endfunction

    function automatic logic [TBL_LOG2-1:0] f_tone_step(input t_tone tone);
        logic [TBL_LOG2-1:0] step;
        unique case (tone)
            TONE_700:  step = STEP_700;
            TONE_900:  step = STEP_900;
            TONE_1100: step = STEP_1100;
            TONE_1300: step = STEP_1300;
            TONE_1500: step = STEP_1500;
            TONE_1700: step = STEP_1700;
            TONE_2400: step = STEP_2400;
            TONE_2600: step = STEP_2600;
            default:   step = '0;
        endcase
        return step;
    endfunction

    function automatic logic [24:0] f_tone_gain(input t_tone tone);
        logic [24:0] gain;
        unique case (tone)
            TONE_700, TONE_900, TONE_1100,
            TONE_1300, TONE_1500, TONE_1700: gain = GAIN_M7DB;
            TONE_2400, TONE_2600:            gain = GAIN_M9DB;
            default:                         gain = '0;
        endcase
        return gain;
    endfunction

    function automatic logic [7:0] f_term_div(input logic [2:0] idx);
        logic [7:0] d;
        unique case (idx)
            3'd1:    d = TERM_DIV_1;
            3'd2:    d = TERM_DIV_2;
            3'd3:    d = TERM_DIV_3;
            3'd4:    d = TERM_DIV_4;
            3'd5:    d = TERM_DIV_5;
            3'd6:    d = TERM_DIV_6;
            default: d = TERM_DIV_1;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] f_term_recip(input logic [2:0] idx);
        logic [31:0] m;
        unique case (idx)
            3'd1:    m = TERM_RECIP_1;
            3'd2:    m = TERM_RECIP_2;
            3'd3:    m = TERM_RECIP_3;
            3'd4:    m = TERM_RECIP_4;
            3'd5:    m = TERM_RECIP_5;
            3'd6:    m = TERM_RECIP_6;
            default: m = TERM_RECIP_1;
        endcase
        return m;
    endfunction

    // G.711 A-law segment encoder
    function automatic logic [7:0] f_alaw(input logic signed [15:0] x);
        logic [11:0] p;
        logic [11:0] sh;
        logic [7:0]  mask;
        logic [3:0]  seg;
        logic [3:0]  nib;
        if (!x[15]) begin
            mask = 8'hD5;
            p    = x[14:3];
        end else begin
            mask = 8'h55;
            p    = ~x[14:3];
        end
        seg = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (32'(p) >= (32'd32 << i)) begin
                seg = 4'(i + 1);
            end
        end
        sh  = p >> seg;
        nib = (seg < 4'd2) ? p[4:1] : sh[3:0];
        return {seg[2:0], nib} ^ mask;
    endfunction

    // G.711 mu-law segment encoder, bias 33, clip at 8159
    function automatic logic [7:0] f_ulaw(input logic signed [15:0] x);
        logic [16:0] mag;
        logic [13:0] p;
        logic [13:0] sh;
        logic [7:0]  mask;
        logic [7:0]  code;
        logic [3:0]  seg;
        if (x[15]) begin
            mask = 8'h7F;
            mag  = 17'd0 - {x[15], x};
            p    = 14'((mag + 17'd3) >> 2);
        end else begin
            mask = 8'hFF;
            mag  = {1'b0, x};
            p    = {1'b0, x[14:2]};
        end
        if (p > 14'd8159) begin
            p = 14'd8159;
        end
        p   = p + 14'd33;
        seg = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (32'(p) >= (32'd64 << i)) begin
                seg = 4'(i + 1);
            end
        end
        sh = p >> (seg + 4'd1);
        if (seg[3]) begin
            code = 8'h7F ^ mask;
        end else begin
            code = {seg[2:0], sh[3:0]} ^ mask;
        end
        return code;
    endfunction

    function automatic logic [7:0] f_compand(input logic signed [15:0] x, input logic law);
        return (law == LAW_MU) ? f_ulaw(x) : f_alaw(x);
    endfunction

endpackage

`default_nettype wire

/* rtl/ss5_dp.sv */
// Datapath: phase, fixed-point sine series, gain scaling and companding.
`default_nettype none

module ss5_dp
    import ss5_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic                i_law_select,
    input  wire logic [7:0]          i_digit_code,
    input  wire logic [TBL_LOG2-1:0] i_start_index,
    output t_dp_status               o_status,
    output logic                     o_strobe,
    output logic [7:0]               o_law_sample,
    output logic                     o_last,
    output logic                     o_unknown_digit
);

    // Transaction context
    logic                r_found;
    t_tone               r_tone1;
    t_tone               r_tone2;
    logic [TBL_LOG2-1:0] r_k;

    // Sine evaluation
    logic [TBL_LOG2-1:0] r_m;
    logic [1:0]          r_quad;
    logic [30:0]         r_th;
    logic [31:0]         r_th2;
    logic [30:0]         r_term;
    logic [31:0]         r_x;
    logic [30:0]         r_qest;
    logic [19:0]         r_rem;
    logic signed [32:0]  r_sum;

    // Gain scaling and sample sum
    logic [31:0]         r_z;
    logic                r_neg;
    logic signed [15:0]  r_acc;

    // Result registers
    logic                r_strobe;
    logic [7:0]          r_law_sample;
    logic                r_last;
    logic                r_unknown;

    t_tone               cur_tone;
    t_digit_info         dec;
    logic [7:0]          term_div;
    logic [31:0]         term_recip;
    logic [FRAC_W:0]     q;
    logic signed [32:0]  sum_abs;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [30:0]         term_new;
    logic signed [32:0]  term_ext;
    logic [13:0]         gain_q;
    logic signed [15:0]  tone_val;

    // Operand selection and the shared multiplier
    always_comb begin
        cur_tone   = i_cmd.tone_sel ? r_tone2 : r_tone1;
        dec        = f_digit_decode(i_digit_code);
        term_div   = f_term_div(i_cmd.term_idx);
        term_recip = f_term_recip(i_cmd.term_idx);
        // fold odd quadrants back onto the rising quarter
        if (r_m[FRAC_W]) begin
            q = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, r_m[FRAC_W-1:0]};
        end else begin
            q = {1'b0, r_m[FRAC_W-1:0]};
        end
        sum_abs = r_sum[32] ? -r_sum : r_sum;
        unique case (i_cmd.op)
            OP_PHASE: begin
                mul_a = 32'(f_tone_step(cur_tone));
                mul_b = 32'(r_k);
            end
            OP_ANGLE: begin
                mul_a = 32'(q);
                mul_b = 32'(HALF_PI_Q30);
            end
            OP_SQR: begin
                mul_a = 32'(r_th);
                mul_b = 32'(r_th);
            end
            OP_TMUL: begin
                mul_a = 32'(r_term);
                mul_b = r_th2;
            end
            OP_TEST: begin
                mul_a = r_x;
                mul_b = term_recip;
            end
            OP_TREM: begin
                mul_a = 32'(r_qest);
                mul_b = 32'(term_div);
            end
            OP_GMUL: begin
                mul_a = sum_abs[31:0];
                mul_b = 32'(f_tone_gain(cur_tone));
            end
            OP_GEST: begin
                mul_a = r_z;
                mul_b = GAIN_RECIP;
            end
            OP_GREM: begin
                mul_a = 32'(r_qest);
                mul_b = GAIN_DIV;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // Quotient corrections: estimates are at most one low
    always_comb begin
        term_new = r_qest + 31'(r_rem >= 20'(term_div));
        term_ext = signed'({2'b00, term_new});
        gain_q   = r_qest[13:0] + 14'(r_rem >= GAIN_DIV[19:0]);
        if (r_neg) begin
            tone_val = 16'sd0 - signed'(16'(gain_q));
        end else begin
            tone_val = signed'(16'(gain_q));
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_found <= dec.found;
                r_tone1 <= dec.tone1;
                r_tone2 <= dec.tone2;
                r_k     <= i_start_index;
                r_acc   <= '0;
            end
            OP_PHASE: r_m <= mul_p[TBL_LOG2-1:0];
            OP_ANGLE: begin
                r_quad <= r_m[TBL_LOG2-1 -: 2];
                r_th   <= mul_p[FRAC_W +: 31];
            end
            OP_SQR: begin
                r_th2  <= mul_p[61:30];
                r_term <= r_th;
                r_sum  <= signed'({2'b00, r_th});
            end
            OP_TMUL: r_x    <= mul_p[61:30];
            OP_TEST: r_qest <= mul_p[62:32];
            OP_TREM: r_rem  <= {10'd0, r_x[9:0] - mul_p[9:0]};
            OP_TFIX: begin
                r_term <= term_new;
                // odd terms of the series are subtracted
                if (i_cmd.term_idx[0]) begin
                    r_sum <= r_sum - term_ext;
                end else begin
                    r_sum <= r_sum + term_ext;
                end
            end
            OP_GMUL: begin
                r_z   <= mul_p[GAIN_SHIFT +: 32];
                r_neg <= r_sum[32] ^ r_quad[1];
            end
            OP_GEST: r_qest <= 31'(mul_p[63:GAIN_QSH]);
            OP_GREM: r_rem  <= r_z[19:0] - mul_p[19:0];
            OP_GFIX: r_acc  <= r_acc + tone_val;
            OP_EMIT: begin
                r_k          <= r_k + TBL_LOG2'(1);
                r_acc        <= '0;
                r_law_sample <= f_compand(r_acc, i_law_select);
                r_last       <= i_cmd.last;
                r_unknown    <= ~r_found;
            end
            default: ;
        endcase
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == OP_EMIT);
        end
    end

    assign o_status.found     = r_found;
    assign o_status.has_tone2 = (r_tone2 != TONE_NONE);
    assign o_strobe           = r_strobe;
    assign o_law_sample       = r_law_sample;
    assign o_last             = r_last;
    assign o_unknown_digit    = r_unknown;

endmodule

`default_nettype wire

/* rtl/ss5_ctrl.sv */
// Controller: sequences the datapath through each sample of a run.
`default_nettype none

module ss5_ctrl
    import ss5_pkg::*;
#(
    parameter int MAX_RUN = DEFAULT_MAX_RUN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [6:0] i_run_length,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [2:0]       r_term_idx;
    logic [2:0]       n_term_idx;
    logic             r_tone_sel;
    logic             n_tone_sel;
    logic [CNT_W-1:0] run_sat;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_term_idx <= 3'd1;
            r_tone_sel <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_term_idx <= n_term_idx;
            r_tone_sel <= n_tone_sel;
        end
    end

    // Run length saturates at the limit
    always_comb begin
        if (int'(i_run_length) > MAX_RUN) begin
            run_sat = CNT_W'(MAX_RUN);
        end else begin
            run_sat = CNT_W'(i_run_length);
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_term_idx     = r_term_idx;
        n_tone_sel     = r_tone_sel;
        o_cmd.op       = OP_NONE;
        o_cmd.term_idx = r_term_idx;
        o_cmd.tone_sel = r_tone_sel;
        o_cmd.last     = (r_count == CNT_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    if (run_sat != '0) begin
                        n_count = run_sat;
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_tone_sel = 1'b0;
                n_state    = i_status.found ? S_PHASE : S_EMIT;
            end
            S_PHASE: begin
                o_cmd.op = OP_PHASE;
                n_state  = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.op = OP_ANGLE;
                n_state  = S_SQR;
            end
            S_SQR: begin
                o_cmd.op   = OP_SQR;
                n_term_idx = 3'd1;
                n_state    = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.op = OP_TMUL;
                n_state  = S_TEST;
            end
            S_TEST: begin
                o_cmd.op = OP_TEST;
                n_state  = S_TREM;
            end
            S_TREM: begin
                o_cmd.op = OP_TREM;
                n_state  = S_TFIX;
            end
            S_TFIX: begin
                o_cmd.op = OP_TFIX;
                if (r_term_idx == 3'(TERM_COUNT)) begin
                    n_state = S_GMUL;
                end else begin
                    n_term_idx = r_term_idx + 3'd1;
                    n_state    = S_TMUL;
                end
            end
            S_GMUL: begin
                o_cmd.op = OP_GMUL;
                n_state  = S_GEST;
            end
            S_GEST: begin
                o_cmd.op = OP_GEST;
                n_state  = S_GREM;
            end
            S_GREM: begin
                o_cmd.op = OP_GREM;
                n_state  = S_GFIX;
            end
            S_GFIX: begin
                o_cmd.op = OP_GFIX;
                if (!r_tone_sel && i_status.has_tone2) begin
                    n_tone_sel = 1'b1;
                    n_state    = S_PHASE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.op   = OP_EMIT;
                n_count    = r_count - CNT_W'(1);
                n_tone_sel = 1'b0;
                if (r_count == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end else if (i_status.found) begin
                    n_state = S_PHASE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/ss5_tone_pair_generator_unit.sv */
// SS5 tone pair generator: one G.711 byte per sample of the tone pair of a digit.
// Each sample evaluates the first tone and, for a two-tone digit, the second; an unknown digit
// skips the evaluation. The unit is busy for a whole run of N and takes no new request until
// idle again; each tone takes 31 sequencer steps around the one 32x32 multiplier.
// Reset is synchronous, active low; it idles the sequencer and selects A-law.
// Result bytes are strobed for one cycle each and cannot be held off by the receiver.
`default_nettype none

module ss5_tone_pair_generator_unit
    import ss5_pkg::*;
#(
    parameter int MAX_RUN = DEFAULT_MAX_RUN
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [7:0]          i_digit_code,
    input  wire logic [TBL_LOG2-1:0] i_start_index,
    input  wire logic [6:0]          i_run_length,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data,
    output logic                     o_out_strobe,
    output logic [7:0]               o_law_sample,
    output logic                     o_last,
    output logic                     o_unknown_digit
);

    logic       r_law_select;
    t_dp_cmd    cmd;
    t_dp_status status;
    logic       ctrl_busy;

    // Companding law register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_law_select <= LAW_A;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_law_select <= i_cfg_data;
        end
    end

    ss5_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_run_length (i_run_length),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_busy       (ctrl_busy)
    );

    ss5_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_law_select    (r_law_select),
        .i_digit_code    (i_digit_code),
        .i_start_index   (i_start_index),
        .o_status        (status),
        .o_strobe        (o_out_strobe),
        .o_law_sample    (o_law_sample),
        .o_last          (o_last),
        .o_unknown_digit (o_unknown_digit)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = ~ctrl_busy;

    // The final byte of a run appears only once the sequencer is idle again
    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_strobe && o_last) |-> !busy)
        else $error("last byte strobed while sequencer still busy");

    // A non-empty transaction always starts the sequencer
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_run_length != 7'd0)) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    // Tone samples need the full series evaluation, never back to back
    a_tone_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_strobe && !o_unknown_digit) |=> !o_out_strobe)
        else $error("tone samples strobed in consecutive cycles");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the SS5 tone pair generator: bit-exact prediction of every G.711 byte.
`timescale 1ns / 1ps

module tb;
    import ss5_pkg::*;

    localparam int SETTLE_CYCLES = 80;    // idle time before a law change
    localparam int DRAIN_CYCLES  = 200;   // tail after the last expected byte
    localparam int REPORT_LIMIT  = 10;

    // One queued stimulus transaction: either a request or a law write
    typedef struct {
        bit          is_cfg;
        logic        law;
        logic [7:0]  digit;
        logic [12:0] first;
        logic [6:0]  count;
    } t_tone_request;

    typedef struct {
        logic [7:0] sample;
        logic       last;
        logic       unknown;
    } t_tone_byte;

    typedef struct packed {
        logic  found;
        t_tone lo;
        t_tone hi;
    } t_tone_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [7:0]  i_digit_code = '0;
    logic [12:0] i_start_index = '0;
    logic [6:0]  i_run_length = '0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        busy;
    logic        o_cfg_ready;
    logic        o_out_strobe;
    logic [7:0]  o_law_sample;
    logic        o_last;
    logic        o_unknown_digit;

    t_tone_request tone_requests[$];
    t_tone_byte    expected_bytes[$];

    logic [7:0] signal_chars [18] = '{CH_1, CH_2, CH_3, CH_4, CH_5, CH_6, CH_7, CH_8, CH_9,
                                      CH_0, CH_STAR, CH_HASH, CH_KP1, CH_KP2, CH_ST,
                                      CH_LINE_A, CH_LINE_B, CH_LINE_C};

    logic law_model = LAW_A;
    int   quiet_cycles = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   mismatch_count = 0;

    ss5_tone_pair_generator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_digit_code    (i_digit_code),
        .i_start_index   (i_start_index),
        .i_run_length    (i_run_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_out_strobe    (o_out_strobe),
        .o_law_sample    (o_law_sample),
        .o_last          (o_last),
        .o_unknown_digit (o_unknown_digit)
    );

    always #5 i_clk = ~i_clk;

    // Tone pair of a signalling character; second tone NONE for single-tone line signals
    function automatic t_tone_pair tone_pair_of(input logic [7:0] code);
        t_tone_pair pair;
        pair = '{found: 1'b1, lo: TONE_NONE, hi: TONE_NONE};
        case (code)
            CH_1:      pair = '{1'b1, TONE_700,  TONE_900};
            CH_2:      pair = '{1'b1, TONE_700,  TONE_1100};
            CH_3:      pair = '{1'b1, TONE_900,  TONE_1100};
            CH_4:      pair = '{1'b1, TONE_700,  TONE_1300};
            CH_5:      pair = '{1'b1, TONE_900,  TONE_1300};
            CH_6:      pair = '{1'b1, TONE_1100, TONE_1300};
            CH_7:      pair = '{1'b1, TONE_700,  TONE_1500};
            CH_8:      pair = '{1'b1, TONE_900,  TONE_1500};
            CH_9:      pair = '{1'b1, TONE_1100, TONE_1500};
            CH_0:      pair = '{1'b1, TONE_1300, TONE_1500};
            CH_STAR:   pair = '{1'b1, TONE_700,  TONE_1700};
            CH_HASH:   pair = '{1'b1, TONE_900,  TONE_1700};
            CH_KP1:    pair = '{1'b1, TONE_1100, TONE_1700};
            CH_KP2:    pair = '{1'b1, TONE_1300, TONE_1700};
            CH_ST:     pair = '{1'b1, TONE_1500, TONE_1700};
            CH_LINE_A: pair = '{1'b1, TONE_2400, TONE_NONE};
            CH_LINE_B: pair = '{1'b1, TONE_2600, TONE_NONE};
            CH_LINE_C: pair = '{1'b1, TONE_2400, TONE_2600};
            default:   pair.found = 1'b0;
        endcase
        return pair;
    endfunction

    // Q30 sine of phase m/TABLE_LENGTH turns, quadrant folded, Taylor series to t^13
    function automatic longint phase_sine(input longint unsigned m);
        longint unsigned u, r, th, th2, term;
        longint          acc;
        int unsigned     quad;
        u    = (m << 32) / 64'(TABLE_LENGTH);
        quad = int'((u >> 30) & 64'd3);
        r    = u & 64'h3FFF_FFFF;
        if (quad[0])
            r = 64'h4000_0000 - r;
        th   = (r * 64'(HALF_PI_Q30)) >> 30;
        th2  = (th * th) >> 30;
        term = th;
        acc  = longint'(th);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return (quad >= 2) ? -acc : acc;
    endfunction

    // Signed contribution of one tone at sample k, truncated toward zero
    function automatic int tone_level(input t_tone tone, input longint unsigned k);
        longint unsigned freq, gain, step, m, mag;
        longint          s, v;
        case (tone)
            TONE_700:  freq = 700;
            TONE_900:  freq = 900;
            TONE_1100: freq = 1100;
            TONE_1300: freq = 1300;
            TONE_1500: freq = 1500;
            TONE_1700: freq = 1700;
            TONE_2400: freq = 2400;
            TONE_2600: freq = 2600;
            default:   freq = 0;
        endcase
        case (tone)
            TONE_2400, TONE_2600: gain = 64'd12589254;
            TONE_NONE:            gain = 64'd0;
            default:              gain = 64'd19952623;
        endcase
        step = (freq * 64'(TABLE_LENGTH) + 64'd4000) / 64'd8000;
        m    = (step * k) % 64'(TABLE_LENGTH);
        s    = phase_sine(m);
        mag  = (s < 0) ? longint'(-s) : longint'(s);
        v    = longint'((mag * gain) / 64'd3276800000000);
        return int'((s < 0) ? -v : v);
    endfunction

    function automatic int unsigned segment_count(input int unsigned v, input int unsigned lim);
        int unsigned seg;
        seg = 0;
        while (seg < 8 && v > lim) begin
            seg++;
            lim = (lim << 1) | 1;
        end
        return seg;
    endfunction

    function automatic logic [7:0] alaw_byte(input int x);
        int unsigned p, seg, val;
        logic [7:0]  mask;
        if (x >= 0) begin
            mask = 8'hD5;
            p    = x >> 3;
        end else begin
            mask = 8'h55;
            p    = (-x - 1) >> 3;
        end
        seg = segment_count(p, 32'h1F);
        if (seg >= 8)
            return 8'h7F ^ mask;
        val = (seg << 4) | (((seg < 2) ? (p >> 1) : (p >> seg)) & 4'hF);
        return val[7:0] ^ mask;
    endfunction

    function automatic logic [7:0] ulaw_byte(input int x);
        int unsigned p, seg, val;
        logic [7:0]  mask;
        if (x < 0) begin
            mask = 8'h7F;
            p    = (-x + 3) >> 2;
        end else begin
            mask = 8'hFF;
            p    = x >> 2;
        end
        if (p > 8159)
            p = 8159;
        p   = p + 33;
        seg = segment_count(p, 32'h3F);
        if (seg >= 8)
            return 8'h7F ^ mask;
        val = (seg << 4) | ((p >> (seg + 1)) & 4'hF);
        return val[7:0] ^ mask;
    endfunction

    // Expected bytes of one accepted request under the current law
    function automatic void queue_run_bytes(input logic [7:0] code, input logic [12:0] first,
                                            input logic [6:0] count);
        t_tone_pair  pair;
        t_tone_byte  b;
        int unsigned len;
        int          level;
        longint unsigned k;
        pair = tone_pair_of(code);
        len  = (count > DEFAULT_MAX_RUN) ? DEFAULT_MAX_RUN : count;
        for (int unsigned n = 0; n < len; n++) begin
            k     = (longint'(first) + n) % TABLE_LENGTH;
            level = pair.found ? tone_level(pair.lo, k) + tone_level(pair.hi, k) : 0;
            b.sample  = (law_model == LAW_MU) ? ulaw_byte(level) : alaw_byte(level);
            b.last    = (n + 1 == len);
            b.unknown = !pair.found;
            expected_bytes.push_back(b);
        end
    endfunction

    function automatic void add_request(input logic [7:0] code, input logic [12:0] first,
                                        input logic [6:0] count);
        t_tone_request req;
        req.is_cfg = 1'b0;
        req.law    = LAW_A;
        req.digit  = code;
        req.first  = first;
        req.count  = count;
        tone_requests.push_back(req);
    endfunction

    function automatic void add_law_write(input logic law);
        t_tone_request req;
        req.is_cfg = 1'b1;
        req.law    = law;
        req.digit  = '0;
        req.first  = '0;
        req.count  = '0;
        tone_requests.push_back(req);
    endfunction

    // Mostly well-formed digits with short runs; some noise codes and long runs
    function automatic void add_random_request();
        logic [7:0]  code;
        logic [6:0]  count;
        int unsigned pick;
        code = ($urandom_range(0, 99) < 85) ? signal_chars[$urandom_range(0, 17)]
                                            : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            count = 7'd0;
        else if (pick < 80)
            count = 7'($urandom_range(1, 8));
        else if (pick < 90)
            count = 7'($urandom_range(9, 63));
        else if (pick < 95)
            count = 7'd64;
        else
            count = 7'($urandom_range(65, 127));
        add_request(code, 13'($urandom_range(0, 8191)), count);
    endfunction

    // Driver: one request or law write per transaction, with bursts and gaps
    always @(posedge i_clk) begin : driver
        t_tone_request req;
        logic free, nx_start, nx_cfg;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_valid  <= 1'b0;
            law_model    = LAW_A;
            quiet_cycles = 0;
        end else begin
            if (start && !busy)
                queue_run_bytes(i_digit_code, i_start_index, i_run_length);
            if (i_cfg_valid && o_cfg_ready)
                law_model = i_cfg_data;
            if (busy || start || i_cfg_valid || expected_bytes.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;

            free     = !((start && busy) || (i_cfg_valid && !o_cfg_ready));
            nx_start = start && !free;
            nx_cfg   = i_cfg_valid && !free;
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tone_requests.size() != 0) begin
                    req = tone_requests[0];
                    if (req.is_cfg) begin
                        // law changes only once the block has gone quiet
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            nx_cfg     = 1'b1;
                            i_cfg_data <= req.law;
                            void'(tone_requests.pop_front());
                        end
                    end else begin
                        nx_start      = 1'b1;
                        i_digit_code  <= req.digit;
                        i_start_index <= req.first;
                        i_run_length  <= req.count;
                        void'(tone_requests.pop_front());
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 10);
                            gap_left   = ($urandom_range(0, 99) < 30) ? 0
                                                                      : $urandom_range(1, 15);
                        end
                    end
                end
            end
            start       <= nx_start;
            i_cfg_valid <= nx_cfg;
        end
    end

    // Monitor: every strobed byte against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_tone_byte want;
        if (i_rst_n && o_out_strobe) begin
            if (expected_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: unexpected byte %02h last %0b unknown %0b",
                             o_law_sample, o_last, o_unknown_digit);
            end else begin
                want = expected_bytes.pop_front();
                if (o_law_sample !== want.sample || o_last !== want.last ||
                    o_unknown_digit !== want.unknown) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.sample, want.last, want.unknown,
                                 o_law_sample, o_last, o_unknown_digit);
                end
            end
        end
    end

    // Stimulus, reset and end of test
    initial begin
        // directed: every digit, start index extremes, unknown codes, zero and long runs
        for (int i = 0; i < 18; i++)
            add_request(signal_chars[i], (i == 0) ? 13'd0 :
                        (i == 1) ? 13'd8191 : 13'($urandom_range(0, 8191)), 7'd2);
        add_request(8'd0, 13'd100, 7'd3);
        add_request(8'hFF, 13'd8190, 7'd2);
        add_request(CH_5, 13'd17, 7'd0);
        add_request(CH_LINE_C, 13'd8160, 7'd64);
        add_request(CH_ST, 13'd8191, 7'd127);

        // random phases across both laws
        add_law_write(LAW_MU);
        for (int i = 0; i < 85; i++)
            add_random_request();
        add_law_write(LAW_A);
        for (int i = 0; i < 80; i++)
            add_random_request();
        add_law_write(LAW_MU);
        for (int i = 0; i < 85; i++)
            add_random_request();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tone_requests.size() != 0 || start || i_cfg_valid)
            @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_bytes.size() != 0)
            $display("mismatch: %0d bytes never arrived", expected_bytes.size());
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: well above every request running the longest two-tone run
    initial begin
        #(60_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
